[hw/rtl/linear_scan_key_value_table_assert.svh]
// ----------------------------------------------------------------------------
// Linear scan key/value table assertion macros
// Clocked, reset-qualified property checks used by the table's checker.
// ----------------------------------------------------------------------------
`ifndef LINEAR_SCAN_KEY_VALUE_TABLE_ASSERT_SVH
`define LINEAR_SCAN_KEY_VALUE_TABLE_ASSERT_SVH

// Check that prop holds at every rising edge of clk outside reset.
`define LSKVT_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("lskvt assertion failed");

// Check that expr never holds at a rising edge of clk outside reset.
`define LSKVT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("lskvt forbidden condition seen");

`endif

[hw/rtl/lskvt_pkg.sv]
// ----------------------------------------------------------------------------
// Linear scan key/value table package
// Sizes, status codes and the request and token types shared by the table.
// ----------------------------------------------------------------------------
package lskvt_pkg;

   localparam int ENTRIES = 64;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = IDX_W + 1;
   localparam int KEY_W   = 64;
   localparam int VAL_W   = 64;
   localparam int STAT_W  = 3;

   localparam logic KIND_LOOKUP = 1'b0;
   localparam logic KIND_SET    = 1'b1;

   localparam logic [STAT_W-1:0] ST_INSERTED = 3'd0;
   localparam logic [STAT_W-1:0] ST_REPLACED = 3'd1;
   localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
   localparam logic [STAT_W-1:0] ST_HIT      = 3'd3;
   localparam logic [STAT_W-1:0] ST_MISS     = 3'd4;

   typedef struct packed {
      logic             kind;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic             active;
      logic             hit;
      logic             ins;
      logic [VAL_W-1:0] data;
   } tok_type;

endpackage

[hw/rtl/lskvt_cell.sv]
// ----------------------------------------------------------------------------
// Linear scan key/value table cell
// Holds one key/value slot, checks the passing request token against it, writes
// the slot on a set, and hands the token to the next cell through a register.
// ----------------------------------------------------------------------------
module lskvt_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [lskvt_pkg::IDX_W-1:0]  cell_index,
   input  logic [lskvt_pkg::CNT_W-1:0]  count,
   input  lskvt_pkg::req_type           req,
   input  lskvt_pkg::tok_type           tok_prev,
   output lskvt_pkg::tok_type           tok_next
);
   import lskvt_pkg::*;

   logic [KEY_W-1:0] key_ff;
   logic [KEY_W-1:0] key_in;
   logic [VAL_W-1:0] value_ff;
   logic [VAL_W-1:0] value_in;
   tok_type          tok_ff;
   tok_type          tok_in;
   logic             occupied;
   logic             free_slot;
   logic             key_match;

   assign occupied  = {1'b0, cell_index} < count;
   assign free_slot = {1'b0, cell_index} == count;
   assign key_match = key_ff == req.key;

   always_comb begin
      tok_in   = tok_prev;
      key_in   = key_ff;
      value_in = value_ff;
      if (tok_prev.active && !tok_prev.hit) begin
         if (occupied && key_match) begin
            tok_in.hit  = 1'b1;
            tok_in.data = value_ff;
            if (req.kind == KIND_SET) begin
               value_in = req.value;
            end
         end else if (free_slot && req.kind == KIND_SET) begin
            key_in     = req.key;
            value_in   = req.value;
            tok_in.ins = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.active <= 1'b0;
      end else begin
         tok_ff.active <= tok_in.active;
      end
      tok_ff.hit  <= tok_in.hit;
      tok_ff.ins  <= tok_in.ins;
      tok_ff.data <= tok_in.data;
      key_ff      <= key_in;
      value_ff    <= value_in;
   end

   assign tok_next = tok_ff;

endmodule

[hw/rtl/linear_scan_key_value_table.sv]
// ----------------------------------------------------------------------------
// Linear scan key/value table
// Up to ENTRIES key/value pairs in insertion order; set and lookup requests
// walk a token down a row of slot cells, one cell per cycle.
//
//   channel   handshake            payload
//   request   start / busy         req_kind, req_key, req_value
//   response  rsp_valid (strobe)   rsp_status, rsp_data
//
// From accept, the request is registered into launch_ff and its token walks
// every cell of the slot row once before the response strobe is registered.
// busy is high from the accept edge until the token leaves the last cell;
// the next request may be accepted on the edge that ends the response beat,
// so a new request is never taken while the last one is still in the row.
// Reset empties the table at once; slot contents are not cleared.
// The response is shown for one cycle and cannot be held off.
// ----------------------------------------------------------------------------
module linear_scan_key_value_table (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_kind,
   input  logic [lskvt_pkg::KEY_W-1:0]   req_key,
   input  logic [lskvt_pkg::VAL_W-1:0]   req_value,
   output logic                          rsp_valid,
   output logic [lskvt_pkg::STAT_W-1:0]  rsp_status,
   output logic [lskvt_pkg::VAL_W-1:0]   rsp_data
);
   import lskvt_pkg::*;

   logic              busy_ff;
   logic              busy_in;
   logic              launch_ff;
   logic              launch_in;
   req_type           req_ff;
   req_type           req_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [STAT_W-1:0] rsp_status_ff;
   logic [STAT_W-1:0] rsp_status_in;
   logic [VAL_W-1:0]  rsp_data_ff;
   logic [VAL_W-1:0]  rsp_data_in;
   logic              accept;
   tok_type           chain [ENTRIES+1];
   tok_type           last;

   assign accept = start && !busy_ff;
   assign last   = chain[ENTRIES];

   assign chain[0] = '{active: launch_ff, hit: 1'b0, ins: 1'b0, data: '0};

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      lskvt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (IDX_W'(i)),
         .count      (count_ff),
         .req        (req_ff),
         .tok_prev   (chain[i]),
         .tok_next   (chain[i+1])
      );
   end

   always_comb begin
      busy_in   = busy_ff;
      launch_in = accept;
      req_in    = req_ff;
      count_in  = count_ff;
      if (accept) begin
         busy_in = 1'b1;
         req_in  = '{kind: req_kind, key: req_key, value: req_value};
      end else if (last.active) begin
         busy_in = 1'b0;
      end
      if (last.active && last.ins) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = last.active;
      rsp_data_in  = last.data;
      if (req_ff.kind == KIND_SET) begin
         if (last.hit) begin
            rsp_status_in = ST_REPLACED;
         end else if (last.ins) begin
            rsp_status_in = ST_INSERTED;
         end else begin
            rsp_status_in = ST_FULL;
         end
      end else begin
         rsp_status_in = last.hit ? ST_HIT : ST_MISS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         launch_ff    <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         launch_ff    <= launch_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign busy       = busy_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

[hw/rtl/lskvt_checker.sv]
// ----------------------------------------------------------------------------
// Linear scan key/value table checker
// Port-level checks on request acceptance and response beats.
// ----------------------------------------------------------------------------
`include "linear_scan_key_value_table_assert.svh"

module lskvt_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          rsp_valid,
   input logic [lskvt_pkg::STAT_W-1:0]  rsp_status,
   input logic [lskvt_pkg::VAL_W-1:0]   rsp_data
);
   import lskvt_pkg::*;

   logic zero_data_due;

   assign zero_data_due = rsp_status == ST_INSERTED || rsp_status == ST_FULL ||
                          rsp_status == ST_MISS;

   `LSKVT_ASSERT(a_accept_busy, clock, reset, (start && !busy) |=> busy)
   `LSKVT_ASSERT(a_single_beat, clock, reset, rsp_valid |=> !rsp_valid)
   `LSKVT_NEVER(a_status_code, clock, reset, rsp_valid && rsp_status > ST_MISS)
   `LSKVT_NEVER(a_zero_data, clock, reset, rsp_valid && zero_data_due && rsp_data != '0)

endmodule

bind linear_scan_key_value_table lskvt_checker u_lskvt_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_valid  (rsp_valid),
   .rsp_status (rsp_status),
   .rsp_data   (rsp_data)
);

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// Linear scan key/value table testbench
// Drives set and lookup beats through the start/busy port and keeps its own
// copy of the table. The copy is updated as each beat is accepted, and every
// response strobe is compared against it, or a directed row's typed response.
// A directed table covers the empty table, extreme keys and values, and
// replace and lookup corners. A random part then fills the table, runs against
// a full table, and mixes in stored keys, keys one bit off them and fresh keys.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import lskvt_pkg::*;

   localparam int RANDOM_BEATS = 750;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DIR_ROWS     = 20;
   localparam logic [KEY_W-1:0] ONES = {KEY_W{1'b1}};
   localparam logic [KEY_W-1:0] MSB  = {1'b1, {(KEY_W-1){1'b0}}};
   localparam logic [KEY_W-1:0] A5   = 64'haaaa_aaaa_aaaa_aaaa;
   localparam logic [KEY_W-1:0] S5   = 64'h5555_5555_5555_5555;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [VAL_W-1:0]  data;
   } rsp_beat_type;

   typedef struct packed {
      logic              kind;
      logic [KEY_W-1:0]  key;
      logic [VAL_W-1:0]  value;
      logic              typed_in;
      logic [STAT_W-1:0] status;
      logic [VAL_W-1:0]  data;
   } dir_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic              req_kind = KIND_LOOKUP;
   logic [KEY_W-1:0]  req_key = '0;
   logic [VAL_W-1:0]  req_value = '0;
   logic              rsp_valid;
   logic [STAT_W-1:0] rsp_status;
   logic [VAL_W-1:0]  rsp_data;

   logic [KEY_W-1:0]  held_keys [ENTRIES];
   logic [VAL_W-1:0]  held_values [ENTRIES];
   int unsigned       held_count = 0;

   rsp_beat_type      rsp_due [$];
   int                fail_count = 0;
   int                cycles = 0;
   int                status_seen [5] = '{default: 0};

   dir_row_type dir_rows [DIR_ROWS] = '{
      '{KIND_LOOKUP, '0,    '0,   1'b1, ST_MISS,     '0},
      '{KIND_LOOKUP, ONES,  ONES, 1'b1, ST_MISS,     '0},
      '{KIND_SET,    '0,    ONES, 1'b1, ST_INSERTED, '0},
      '{KIND_SET,    ONES,  '0,   1'b1, ST_INSERTED, '0},
      '{KIND_LOOKUP, '0,    '0,   1'b1, ST_HIT,      ONES},
      '{KIND_LOOKUP, ONES,  S5,   1'b1, ST_HIT,      '0},
      '{KIND_SET,    '0,    S5,   1'b1, ST_REPLACED, ONES},
      '{KIND_LOOKUP, '0,    '0,   1'b1, ST_HIT,      S5},
      '{KIND_LOOKUP, 64'd1, '0,   1'b1, ST_MISS,     '0},
      '{KIND_LOOKUP, MSB,   '0,   1'b1, ST_MISS,     '0},
      '{KIND_SET,    MSB,   A5,   1'b1, ST_INSERTED, '0},
      '{KIND_SET,    64'd1, 64'd1, 1'b1, ST_INSERTED, '0},
      '{KIND_LOOKUP, ~MSB,  '0,   1'b0, ST_MISS,     '0},
      '{KIND_SET,    MSB,   '0,   1'b1, ST_REPLACED, A5},
      '{KIND_LOOKUP, ONES - 64'd1, '0, 1'b1, ST_MISS, '0},
      '{KIND_SET,    ONES,  ONES, 1'b1, ST_REPLACED, '0},
      '{KIND_LOOKUP, 64'd1, A5,   1'b1, ST_HIT,      64'd1},
      '{KIND_LOOKUP, MSB,   '0,   1'b1, ST_HIT,      '0},
      '{KIND_SET,    64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 1'b0, ST_INSERTED, '0},
      '{KIND_LOOKUP, 64'h0123_4567_89ab_cdef, '0, 1'b0, ST_HIT, '0}
   };

   linear_scan_key_value_table dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_kind   (req_kind),
      .req_key    (req_key),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_status (rsp_status),
      .rsp_data   (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic rsp_beat_type table_apply(input logic kind, input logic [KEY_W-1:0] key,
                                                input logic [VAL_W-1:0] value);
      rsp_beat_type beat;
      int           slot;
      int unsigned  i;
      beat.status = ST_MISS;
      beat.data   = '0;
      slot        = -1;
      for (i = 0; i < held_count; i++) begin
         if (slot < 0 && held_keys[i] == key) begin
            slot = i;
         end
      end
      if (kind == KIND_SET) begin
         if (slot >= 0) begin
            beat.status       = ST_REPLACED;
            beat.data         = held_values[slot];
            held_values[slot] = value;
         end else if (held_count < ENTRIES) begin
            beat.status             = ST_INSERTED;
            held_keys[held_count]   = key;
            held_values[held_count] = value;
            held_count++;
         end else begin
            beat.status = ST_FULL;
         end
      end else if (slot >= 0) begin
         beat.status = ST_HIT;
         beat.data   = held_values[slot];
      end
      return beat;
   endfunction

   function automatic logic [63:0] rand_word();
      int unsigned r;
      r = $urandom_range(9);
      if (r == 0) begin
         return '0;
      end else if (r == 1) begin
         return ONES;
      end
      return {$urandom, $urandom};
   endfunction

   function automatic logic [KEY_W-1:0] stored_key();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 15) begin
         return held_keys[0];
      end else if (r < 30) begin
         return held_keys[held_count-1];
      end
      return held_keys[$urandom_range(held_count-1)];
   endfunction

   function automatic int idle_cycles();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 50) begin
         return $urandom_range(3);
      end else if (r < 88) begin
         return $urandom_range(80, 4);
      end
      return $urandom_range(300, 100);
   endfunction

   task automatic send_request(input logic kind, input logic [KEY_W-1:0] key,
                               input logic [VAL_W-1:0] value, input logic typed_in,
                               input rsp_beat_type typed_rsp);
      rsp_beat_type predicted;
      int           gap;
      @(negedge clock);
      start     <= 1'b1;
      req_kind  <= kind;
      req_key   <= key;
      req_value <= value;
      do @(posedge clock); while (busy !== 1'b0);
      predicted = table_apply(kind, key, value);
      rsp_due.push_back(typed_in ? typed_rsp : predicted);
      status_seen[predicted.status]++;
      gap = idle_cycles();
      if (gap > 0) begin
         @(negedge clock);
         start     <= 1'b0;
         req_kind  <= $urandom_range(1);
         req_key   <= {$urandom, $urandom};
         req_value <= {$urandom, $urandom};
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic random_request();
      int unsigned      r;
      logic             kind;
      logic [KEY_W-1:0] key;
      rsp_beat_type     none;
      none = '0;
      r    = $urandom_range(99);
      if (held_count == 0 || r < 30) begin
         kind = (held_count == 0) ? logic'($urandom_range(1)) : KIND_SET;
         key  = rand_word();
      end else if (r < 45) begin
         kind = KIND_SET;
         key  = stored_key();
      end else if (r < 70) begin
         kind = KIND_LOOKUP;
         key  = stored_key();
      end else if (r < 85) begin
         kind = KIND_LOOKUP;
         key  = stored_key() ^ (64'd1 << $urandom_range(63));
      end else if (r < 92) begin
         kind = KIND_SET;
         key  = stored_key() ^ (64'd1 << $urandom_range(63));
      end else begin
         kind = KIND_LOOKUP;
         key  = {$urandom, $urandom};
      end
      send_request(kind, key, rand_word(), 1'b0, none);
   endtask

   always @(posedge clock) begin
      rsp_beat_type want;
      if (!reset && rsp_valid !== 1'b0) begin
         if (rsp_due.size() == 0) begin
            $display("%0t: unexpected beat status %0d data %h", $time, rsp_status, rsp_data);
            fail_count++;
         end else begin
            want = rsp_due.pop_front();
            if (rsp_valid !== 1'b1 || rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d (strobe %b)", $time,
                        want.status, rsp_status, rsp_valid);
               fail_count++;
            end
            if (rsp_data !== want.data) begin
               $display("%0t: data expected %h actual %h", $time, want.data, rsp_data);
               fail_count++;
            end
         end
      end
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles, %0d beats outstanding", cycles, rsp_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (dir_rows[i]) begin
         send_request(dir_rows[i].kind, dir_rows[i].key, dir_rows[i].value,
                      dir_rows[i].typed_in, {dir_rows[i].status, dir_rows[i].data});
      end
      repeat (RANDOM_BEATS) random_request();
      @(negedge clock);
      start <= 1'b0;
      while (rsp_due.size() != 0) @(posedge clock);
      repeat (ENTRIES + 8) @(posedge clock);
      $display("%0d directed and %0d random beats; table holds %0d of %0d slots",
               DIR_ROWS, RANDOM_BEATS, held_count, ENTRIES);
      $display("inserted %0d, replaced %0d, full %0d, hit %0d, miss %0d",
               status_seen[ST_INSERTED], status_seen[ST_REPLACED], status_seen[ST_FULL],
               status_seen[ST_HIT], status_seen[ST_MISS]);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
